FILE: hdl/depth_pixel_backprojection_core_macros.svh
// ----------------------------------------------------------------------------
// Depth pixel back-projection: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_MACROS_SVH

// Same-cycle implication
`define DPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dpb_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection: package
// Widths, register reset values, register indexes and pipeline types.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Pixel coordinates are taken modulo 2^COORD_BITS
  localparam int COORD_BITS = 12;
  localparam int PIX_W      = 12;
  localparam int PIX_EXT_W  = (PIX_W > COORD_BITS) ? PIX_W : COORD_BITS;

  // Signed-magnitude pixel offset in Q.4, and its product with z (Q.20)
  localparam int DIFF_W = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
  localparam int A_W    = DIFF_W + 32;

  localparam int DEPTH_W  = 16;
  localparam int CENTER_W = 16;
  localparam int INV_F_W  = 24;
  localparam int SCALE_W  = 32;
  localparam int COORD_W  = 32;
  localparam int COLOR_W  = 8;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 120;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register stages from input to output register
  localparam int NUM_STAGES = 5;

  // Register reset values
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 16'd5208;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 16'd4056;
  localparam logic [INV_F_W-1:0]  INV_FX_RST   = 24'd32389;
  localparam logic [INV_F_W-1:0]  INV_FY_RST   = 24'd32326;
  localparam logic [SCALE_W-1:0]  SCALE_RST    = 32'd4294967;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_INV_FX    = 3'd2,
    REG_INV_FY    = 3'd3,
    REG_INV_SCALE = 3'd4
  } cfg_reg_t;

  // Per-stage load enables, bit k loads stage k+1
  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

FILE: hdl/depth_pixel_backprojection_core.sv
// An accepted input transaction reaches out_tvalid through five register stages.
// Throughput: one pixel per cycle while out_tready is high; the five-stage
//   multiply pipeline then takes a new transaction every cycle and each stage
//   stalls only when it and all stages after it hold data.
// Zero-depth pixels are accepted and produce no output transaction.
// Reset (rst_n, synchronous): pipeline emptied, registers to default intrinsics.
// ----------------------------------------------------------------------------
// Depth pixel back-projection core
// Turns a depth pixel into a Q16.16 3D point with pass-through color.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_core import dpb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] pixel_column, [23:12] pixel_row, [39:24] depth_raw,
  // [47:40] blue_in, [55:48] green_in, [63:56] red_in
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] point_x, [63:32] point_y, [95:64] point_z,
  // [103:96] blue_out, [111:104] green_out, [119:112] red_out
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Register write port
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "depth_pixel_backprojection_core_macros.svh"

  localparam int COLOR3_W = 3 * COLOR_W;

  logic [CENTER_W-1:0] center_x_r, center_y_r;
  logic [INV_F_W-1:0]  inv_fx_r, inv_fy_r;
  logic [SCALE_W-1:0]  scale_r;

  logic [PIX_W-1:0]    in_col, in_row;
  logic [DEPTH_W-1:0]  in_depth;
  logic [COLOR3_W-1:0] in_color;

  logic [NUM_STAGES-1:0] v_r;
  stage_en_t             en;

  logic [47:0]         zp1_r;
  logic [31:0]         z2_r, z3_r, z4_r, z5_r;
  logic [32:0]         z_round;
  logic [COLOR3_W-1:0] color_r [NUM_STAGES];

  logic [COORD_W-1:0]  x_out, y_out;

  // Register writes, taken at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      inv_fx_r   <= INV_FX_RST;
      inv_fy_r   <= INV_FY_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X:  center_x_r <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:  center_y_r <= cfg_data[CENTER_W-1:0];
        REG_INV_FX:    inv_fx_r   <= cfg_data[INV_F_W-1:0];
        REG_INV_FY:    inv_fy_r   <= cfg_data[INV_F_W-1:0];
        REG_INV_SCALE: scale_r    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack input transaction
  assign in_col   = in_tdata[11:0];
  assign in_row   = in_tdata[23:12];
  assign in_depth = in_tdata[39:24];
  assign in_color = in_tdata[63:40];

  // Per-stage flow control: a stage loads when empty or when its successor loads
  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  // Valid bits; zero depth enters as a bubble
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid && (in_depth != '0);
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Color pass-through line
  always_ff @(posedge clk) begin
    if (en[0]) begin
      color_r[0] <= in_color;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        color_r[k] <= color_r[k-1];
      end
    end
  end

  // Stage 1: depth times reciprocal scale, Q16.32
  always_ff @(posedge clk) begin
    if (en[0]) begin
      zp1_r <= 48'(in_depth) * 48'(scale_r);
    end
  end

  // Stage 2: round to Q16.16 and saturate
  assign z_round = 33'((49'(zp1_r) + 49'(1 << 15)) >> 16);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      z2_r <= z_round[32] ? 32'hFFFF_FFFF : z_round[31:0];
    end
  end

  // Stages 3 to 5: carry z alongside the lateral units
  always_ff @(posedge clk) begin
    if (en[2]) begin
      z3_r <= z2_r;
    end
    if (en[3]) begin
      z4_r <= z3_r;
    end
    if (en[4]) begin
      z5_r <= z4_r;
    end
  end

  // Horizontal coordinate
  dpb_lateral u_lat_x (
    .clk      (clk),
    .en       (en),
    .pix_i    (in_col),
    .center_i (center_x_r),
    .inv_f_i  (inv_fx_r),
    .z_i      (z2_r),
    .coord_o  (x_out)
  );

  // Vertical coordinate
  dpb_lateral u_lat_y (
    .clk      (clk),
    .en       (en),
    .pix_i    (in_row),
    .center_i (center_y_r),
    .inv_f_i  (inv_fy_r),
    .z_i      (z2_r),
    .coord_o  (y_out)
  );

  // Output register is stage 5
  assign out_tvalid = v_r[NUM_STAGES-1];
  assign out_tdata  = {color_r[NUM_STAGES-1], z5_r, y_out, x_out};

  // Checks
  `DPB_ASSERT_NEXT(a_zero_depth_drop, in_tvalid && in_tready && (in_depth == '0), !v_r[0], "zero depth entered pipeline")
  `DPB_ASSERT_NEXT(a_depth_enters, in_tvalid && in_tready && (in_depth != '0), v_r[0], "accepted pixel lost at stage 1")
  `DPB_ASSERT_NOW(a_stall_only_full, !in_tready, &v_r, "input stalled with a bubble in pipeline")

endmodule

FILE: hdl/dpb_lateral.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection: lateral coordinate unit
// Computes (pix*16 - center) * z * inv_f in Q16.16 with round half away from
// zero and 32-bit signed saturation, over pipeline stages 1 to 5.
// ----------------------------------------------------------------------------
module dpb_lateral import dpb_pkg::*; (
  input  logic                clk,
  input  stage_en_t           en,
  input  logic [PIX_W-1:0]    pix_i,     // stage 1 input
  input  logic [CENTER_W-1:0] center_i,
  input  logic [INV_F_W-1:0]  inv_f_i,
  input  logic [31:0]         z_i,       // stage 2 output
  output logic [COORD_W-1:0]  coord_o    // stage 5 output
);

  localparam int HI_W  = A_W;
  localparam int LO_W  = 48;
  localparam int SUM_W = HI_W + 1;
  localparam int MAG_W = SUM_W - 4;

  logic [PIX_EXT_W-1:0]  pix_ext;
  logic [DIFF_W-1:0]     p4;
  logic [DIFF_W-1:0]     ctr;
  logic                  neg;

  logic                  neg1_r, neg2_r, neg3_r, neg4_r;
  logic [DIFF_W-1:0]     magd1_r, magd2_r;
  logic [A_W-1:0]        a3_r;
  logic [HI_W-1:0]       hi4_r;
  logic [LO_W-1:0]       lo4_r;
  logic [COORD_W-1:0]    coord5_r;

  logic [LO_W:0]         lo_sum;
  logic [SUM_W-1:0]      hi_sum;
  logic [MAG_W-1:0]      mag;
  logic [COORD_W-1:0]    coord_nxt;

  // Stage 1: signed-magnitude offset of the pixel from the principal point
  assign pix_ext = PIX_EXT_W'(pix_i);
  assign p4      = DIFF_W'({pix_ext[COORD_BITS-1:0], 4'b0000});
  assign ctr     = DIFF_W'(center_i);
  assign neg     = p4 < ctr;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg1_r  <= neg;
      magd1_r <= neg ? (ctr - p4) : (p4 - ctr);
    end
  end

  // Stage 2: wait for z
  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg2_r  <= neg1_r;
      magd2_r <= magd1_r;
    end
  end

  // Stage 3: offset times z, Q.20
  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg3_r <= neg2_r;
      a3_r   <= A_W'(magd2_r) * A_W'(z_i);
    end
  end

  // Stage 4: split product by the reciprocal focal length
  always_ff @(posedge clk) begin
    if (en[3]) begin
      neg4_r <= neg3_r;
      hi4_r  <= HI_W'(a3_r[A_W-1:24]) * HI_W'(inv_f_i);
      lo4_r  <= LO_W'(a3_r[23:0]) * LO_W'(inv_f_i);
    end
  end

  // Stage 5: recombine, round to Q.16, saturate and apply sign
  always_comb begin
    lo_sum = {1'b0, lo4_r} + (LO_W+1)'(64'd1 << 27);
    hi_sum = SUM_W'(hi4_r) + SUM_W'(lo_sum >> 24);
    mag    = hi_sum[SUM_W-1:4];
    if (neg4_r) begin
      if (mag > MAG_W'(64'h8000_0000)) begin
        coord_nxt = 32'h8000_0000;
      end else begin
        coord_nxt = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > MAG_W'(64'h7FFF_FFFF)) begin
        coord_nxt = 32'h7FFF_FFFF;
      end else begin
        coord_nxt = mag[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      coord5_r <= coord_nxt;
    end
  end

  assign coord_o = coord5_r;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth pixel back-projection core testbench
// Streams depth pixels through the core under several camera intrinsics and
// checks every point against an in-bench fixed-point projection. Both stream
// sides idle at random, and intrinsics change only while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import dpb_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 2;
  localparam int SETTLE_CYCLES = NUM_STAGES + 3;
  localparam int REG_COUNT     = int'(REG_INV_SCALE) + 1;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 150;
  localparam int TIMEOUT_NS    = 5_000_000;

  // One depth pixel and one projected point
  typedef struct packed {
    logic [PIX_W-1:0]   column;
    logic [PIX_W-1:0]   row;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } point_t;

  // Flavors of random intrinsics
  typedef enum int {CAM_TYPICAL, CAM_WILD, CAM_EXTREME} camera_mix_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Bench copy of the camera intrinsics
  logic [CENTER_W-1:0] cam_center_x  = CENTER_X_RST;
  logic [CENTER_W-1:0] cam_center_y  = CENTER_Y_RST;
  logic [INV_F_W-1:0]  cam_inv_fx    = INV_FX_RST;
  logic [INV_F_W-1:0]  cam_inv_fy    = INV_FY_RST;
  logic [SCALE_W-1:0]  cam_inv_scale = SCALE_RST;

  point_t expected_points[$];
  point_t rx_point;
  point_t rx_expect;
  int     error_count = 0;
  int     rx_hold     = 0;
  bit     tx_gaps     = 1'b1;
  bit     rx_stalls   = 1'b1;

  depth_pixel_backprojection_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Lateral coordinate: signed-magnitude Q.4 offset times z times 1/f,
  // magnitude rounded half away from zero, then saturated to signed Q16.16
  function automatic logic [COORD_W-1:0] lateral_offset(input logic [PIX_W-1:0] pix,
                                                        input logic [CENTER_W-1:0] center,
                                                        input logic [COORD_W-1:0] z,
                                                        input logic [INV_F_W-1:0] inv_f);
    logic [CENTER_W-1:0] p4;
    logic [CENTER_W-1:0] mag_d;
    logic                neg;
    logic [79:0]         mag;
    p4    = {pix[COORD_BITS-1:0], 4'b0000};
    neg   = p4 < center;
    mag_d = neg ? center - p4 : p4 - center;
    mag   = (80'(mag_d) * 80'(z) * 80'(inv_f) + (80'd1 << 27)) >> 28;
    if (neg) begin
      if (mag > 80'h8000_0000) mag = 80'h8000_0000;
      return -mag[COORD_W-1:0];
    end
    if (mag > 80'h7FFF_FFFF) mag = 80'h7FFF_FFFF;
    return mag[COORD_W-1:0];
  endfunction

  function automatic point_t project_pixel(input pixel_t px);
    point_t      pt;
    logic [48:0] z_wide;
    // Q16.32 depth product rounded to Q16.16
    z_wide   = (49'(px.depth) * 49'(cam_inv_scale) + 49'd32768) >> 16;
    pt.z     = (z_wide > 49'hFFFF_FFFF) ? '1 : z_wide[COORD_W-1:0];
    pt.x     = lateral_offset(px.column, cam_center_x, pt.z, cam_inv_fx);
    pt.y     = lateral_offset(px.row, cam_center_y, pt.z, cam_inv_fy);
    pt.blue  = px.blue;
    pt.green = px.green;
    pt.red   = px.red;
    return pt;
  endfunction

  function automatic pixel_t make_pixel(input int column, input int row, input int depth,
                                        input logic [COLOR_W-1:0] blue,
                                        input logic [COLOR_W-1:0] green,
                                        input logic [COLOR_W-1:0] red);
    pixel_t px;
    px = '{PIX_W'(column), PIX_W'(row), DEPTH_W'(depth), blue, green, red};
    return px;
  endfunction

  // Random pixel, biased toward missing, extreme and near-range depths and
  // toward image borders and the principal point
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     pick;
    px   = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick < 2) px.depth = '0;
    else if (pick == 2) px.depth = DEPTH_W'(1);
    else if (pick == 3) px.depth = '1;
    else if (pick < 12) px.depth = DEPTH_W'($urandom_range(200, 8000));
    pick = $urandom_range(0, 9);
    if (pick == 0) px.column = cam_center_x[CENTER_W-1:4];
    else if (pick == 1) px.column = '0;
    else if (pick == 2) px.column = '1;
    pick = $urandom_range(0, 9);
    if (pick == 0) px.row = cam_center_y[CENTER_W-1:4];
    else if (pick == 1) px.row = '0;
    else if (pick == 2) px.row = '1;
    return px;
  endfunction

  // Send one pixel; valid stays high unless an idle burst follows
  task automatic send_pixel(input pixel_t px);
    in_tvalid <= 1'b1;
    in_tdata  <= {px.red, px.green, px.blue, px.depth, px.row, px.column};
    do @(posedge clk); while (!in_tready);
    if (px.depth != '0) expected_points = {expected_points, project_pixel(px)};
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    // zero-depth pixels may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CENTER_X:  cam_center_x  = value[CENTER_W-1:0];
      REG_CENTER_Y:  cam_center_y  = value[CENTER_W-1:0];
      REG_INV_FX:    cam_inv_fx    = value[INV_F_W-1:0];
      REG_INV_FY:    cam_inv_fy    = value[INV_F_W-1:0];
      REG_INV_SCALE: cam_inv_scale = value[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // Drain the pipeline, then load all intrinsics; optionally also hit the
  // unused register indexes, which must be ignored
  task automatic program_camera(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                                input logic [CFG_DATA_W-1:0] fx, input logic [CFG_DATA_W-1:0] fy,
                                input logic [CFG_DATA_W-1:0] scale, input bit junk);
    wait_idle();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_INV_FX, fx);
    write_reg(REG_INV_FY, fy);
    write_reg(REG_INV_SCALE, scale);
    if (junk) begin
      for (int k = REG_COUNT; k < 2**CFG_IDX_W; k++) write_reg(CFG_IDX_W'(k), $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_camera(input camera_mix_t mix);
    logic [CFG_DATA_W-1:0] v [REG_COUNT];
    case (mix)
      CAM_TYPICAL: begin
        v[REG_CENTER_X]  = $urandom_range(0, 65535);
        v[REG_CENTER_Y]  = $urandom_range(0, 65535);
        v[REG_INV_FX]    = $urandom_range(8000, 200000);
        v[REG_INV_FY]    = $urandom_range(8000, 200000);
        v[REG_INV_SCALE] = $urandom_range(0, 1 << 26);
      end
      CAM_WILD: begin
        foreach (v[k]) v[k] = $urandom >> $urandom_range(0, 24);
      end
      default: begin
        foreach (v[k]) begin
          case ($urandom_range(0, 2))
            0:       v[k] = '0;
            1:       v[k] = '1;
            default: v[k] = $urandom;
          endcase
        end
      end
    endcase
    program_camera(v[REG_CENTER_X], v[REG_CENTER_Y], v[REG_INV_FX], v[REG_INV_FY],
                   v[REG_INV_SCALE], 1'($urandom_range(0, 1)));
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
      error_count++;
    end
  endtask

  // Receiver: random stall bursts
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 9) == 0) begin
      rx_hold    <= $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest expected point
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rx_point.x     = out_tdata[31:0];
      rx_point.y     = out_tdata[63:32];
      rx_point.z     = out_tdata[95:64];
      rx_point.blue  = out_tdata[103:96];
      rx_point.green = out_tdata[111:104];
      rx_point.red   = out_tdata[119:112];
      if (expected_points.size() == 0) begin
        $error("point transaction with nothing expected: 0x%h", out_tdata);
        error_count++;
      end else begin
        rx_expect = expected_points.pop_front();
        check_field("point_x", rx_expect.x, rx_point.x);
        check_field("point_y", rx_expect.y, rx_point.y);
        check_field("point_z", rx_expect.z, rx_point.z);
        check_field("blue_out", COORD_W'(rx_expect.blue), COORD_W'(rx_point.blue));
        check_field("green_out", COORD_W'(rx_expect.green), COORD_W'(rx_point.green));
        check_field("red_out", COORD_W'(rx_expect.red), COORD_W'(rx_point.red));
      end
    end
  end

  // Intrinsics straight out of reset
  task automatic test_reset_intrinsics();
    send_pixel(make_pixel(0, 0, 1000, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(4095, 4095, 65535, 8'hFF, 8'hFF, 8'hFF));
    // half a pixel either side of the principal point
    send_pixel(make_pixel(325, 253, 1000, 8'h01, 8'h02, 8'h03));
    send_pixel(make_pixel(326, 254, 5000, 8'hA5, 8'h5A, 8'h3C));
    send_pixel(make_pixel(4095, 0, 1, 8'h80, 8'h40, 8'h01));
    // no measurement
    send_pixel(make_pixel(0, 4095, 0, 8'hFF, 8'h00, 8'hFF));
    send_pixel(make_pixel(2048, 1024, 32768, 8'h0F, 8'hF0, 8'h77));
  endtask

  task automatic test_extreme_settings();
    // All zero: every product collapses to zero
    program_camera('0, '0, '0, '0, '0, 1'b0);
    send_pixel(make_pixel(4095, 4095, 65535, 8'h12, 8'h34, 8'h56));
    send_pixel(make_pixel(0, 0, 1, 8'h9A, 8'hBC, 8'hDE));
    // Largest settings: offsets negative, far ones saturate
    program_camera(32'hFFFF, 32'hFFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pixel(make_pixel(0, 0, 65535, 8'h11, 8'h22, 8'h33));
    send_pixel(make_pixel(4095, 4095, 1, 8'h44, 8'h55, 8'h66));
    send_pixel(make_pixel(0, 4095, 0, 8'h77, 8'h88, 8'h99));
    send_pixel(make_pixel(4095, 0, 300, 8'hAA, 8'hBB, 8'hCC));
    // Bits above the register widths set: centers at the origin, positive saturation
    program_camera(32'hFFFF_0000, 32'hABCD_0000, 32'hFFFF_FFFF, 32'h5AFF_FFFF,
                   32'hFFFF_FFFF, 1'b1);
    send_pixel(make_pixel(4095, 4095, 65535, 8'hFE, 8'h01, 8'h7F));
    send_pixel(make_pixel(0, 0, 65535, 8'h01, 8'hFE, 8'h80));
    send_pixel(make_pixel(1, 4095, 2, 8'h55, 8'hAA, 8'h5A));
    // zero depth just ahead of the next register writes
    send_pixel(make_pixel(100, 100, 0, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random_frames();
    camera_mix_t mix;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 2) mix = CAM_EXTREME;
      else if (phase % 3 == 1) mix = CAM_WILD;
      else mix = CAM_TYPICAL;
      random_camera(mix);
      // last stretch runs with both sides always ready
      if (phase == PHASES - 1) begin
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_idle();
        send_pixel(random_pixel());
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_intrinsics();
    test_extreme_settings();
    test_random_frames();
    wait_idle();
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/dpb_pkg.sv
hdl/dpb_lateral.sv
hdl/depth_pixel_backprojection_core.sv
tb/testbench.sv
